[sv/vhll_pkg.sv]
// Shared types and constants for the virtual HLL spread sketch.
package vhll_pkg;

  localparam int unsigned PHYS_DEPTH_DEF = 4096;
  localparam int unsigned VIRT_COUNT_DEF = 16;

  localparam logic [5:0]  RANK_OF_ZERO = 6'd32;
  localparam logic [12:0] PHYS_COUNT_RST = 13'd4096;

  // MurmurHash3 x86_32 constants
  localparam logic [31:0] MM_C1   = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2   = 32'h1b873593;
  localparam logic [31:0] MM_C3   = 32'h85ebca6b;
  localparam logic [31:0] MM_C4   = 32'hc2b2ae35;
  localparam logic [31:0] MM_MIX  = 32'he6546b64;
  localparam logic [31:0] MM_FIVE = 32'd5;
  localparam logic [31:0] MM_LEN  = 32'd4;

  typedef enum logic [1:0] {
    CMD_INSERT    = 2'd0,
    CMD_QUERY     = 2'd1,
    CMD_LOAD_SEED = 2'd2
  } cmd_t;

  typedef enum logic [0:0] {
    REG_ELEMENT_SEED = 1'b0,
    REG_PHYS_COUNT   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic        start;
    logic [31:0] key;
    logic [31:0] seed;
  } hash_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] value;
  } hash_rsp_t;

endpackage

[sv/vhll_hash.sv]
// Multi-cycle MurmurHash3 x86_32 of one word around a single shared multiplier.
module vhll_hash (
  input  logic            clk,
  input  logic            rst,
  input  vhll_pkg::hash_req_t req,
  output vhll_pkg::hash_rsp_t rsp
);
  import vhll_pkg::*;

  logic [31:0] key_r;
  logic [31:0] seed_r;
  logic [31:0] x;
  logic [2:0]  step;
  logic        busy;
  logic        done;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] prod;
  logic [31:0] mix_in;

  assign mix_in = seed_r ^ x;

  // Pick multiplier operands for each round
  always_comb begin
    case (step)
      3'd0: begin
        mul_a = key_r;
        mul_b = MM_C1;
      end
      3'd1: begin
        mul_a = {x[16:0], x[31:17]};
        mul_b = MM_C2;
      end
      3'd2: begin
        mul_a = {mix_in[18:0], mix_in[31:19]};
        mul_b = MM_FIVE;
      end
      3'd3: begin
        mul_a = x ^ (x >> 16);
        mul_b = MM_C3;
      end
      default: begin
        mul_a = x ^ (x >> 13);
        mul_b = MM_C4;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 3'd1;
        if (step == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      key_r  <= req.key;
      seed_r <= req.seed;
    end else if (busy) begin
      if (step == 3'd2) begin
        x <= (prod + MM_MIX) ^ MM_LEN;
      end else begin
        x <= prod;
      end
    end
  end

  assign rsp.done  = done;
  assign rsp.value = x ^ (x >> 16);

endmodule

[sv/vhll_mod.sv]
// Bit-serial restoring remainder of a 32-bit word by the physical count.
module vhll_mod #(
  parameter int unsigned DW = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [31:0]   dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] remainder
);
  import vhll_pkg::*;

  logic [31:0]   dvd;
  logic [DW-1:0] div_r;
  logic [DW-1:0] rem;
  logic [4:0]    count;
  logic          busy;
  logic [DW:0]   trial;

  assign trial = {rem, dvd[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 5'd1;
        if (count == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // One quotient bit per cycle; keep the partial remainder below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      dvd   <= dividend;
      div_r <= divisor;
      rem   <= '0;
    end else if (busy) begin
      dvd <= {dvd[30:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        rem <= DW'(trial - {1'b0, div_r});
      end else begin
        rem <= trial[DW-1:0];
      end
    end
  end

  assign remainder = rem;

endmodule

[sv/virtual_hll_spread_sketch.sv]
// Top level: sequencer, seed table and physical rank memory of the spread sketch.
// One item at a time. After reset the rank memory is swept to zero, one entry per
// cycle, and no item is taken during the sweep. A seed load is written into the
// seed table when it is accepted. Every physical position costs a seed read, one
// hash start and a hash on the shared multiplier, a bit-serial remainder and a
// memory read and update. An insert first computes the element hash, which picks
// the virtual register and the rank, and then visits one physical position. A
// query visits each of the VIRT_COUNT virtual registers and emits one result per
// virtual register, waiting on any output stall. The remainder unit sets the pace.
module virtual_hll_spread_sketch #(
  parameter int unsigned PHYS_DEPTH = vhll_pkg::PHYS_DEPTH_DEF,
  parameter int unsigned VIRT_COUNT = vhll_pkg::VIRT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [31:0] source,
  input  logic [31:0] destination,
  input  logic [3:0]  seed_index,
  input  logic [31:0] seed_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  rank_value,
  output logic [3:0]  virtual_index,
  output logic        last
);
  import vhll_pkg::*;

  localparam int unsigned AW = $clog2(PHYS_DEPTH);
  localparam int unsigned DW = $clog2(PHYS_DEPTH + 1);
  localparam int unsigned VW = $clog2(VIRT_COUNT);

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_EHASH  = 10'b0000000100,
    S_SEEDRD = 10'b0000001000,
    S_HSTART = 10'b0000010000,
    S_SHASH  = 10'b0000100000,
    S_MOD    = 10'b0001000000,
    S_READ   = 10'b0010000000,
    S_USE    = 10'b0100000000,
    S_EMIT   = 10'b1000000000
  } state_t;

  function automatic logic [5:0] rank_of(input logic [31:0] h);
    logic [5:0] r;
    r = RANK_OF_ZERO;
    for (int i = 0; i < 32; i++) begin
      if (h[i]) r = 6'(32 - i);
    end
    return r;
  endfunction

  state_t state;
  state_t state_next;

  logic [31:0]   element_seed;
  logic [12:0]   phys_count;
  logic [DW-1:0] used_count;

  logic [31:0] seeds [VIRT_COUNT];
  logic [31:0] seed_q;
  logic [5:0]  ranks [PHYS_DEPTH];
  logic [5:0]  rank_q;

  logic          is_insert;
  logic [31:0]   src_r;
  logic [VW-1:0] vidx;
  logic [5:0]    rank;
  logic [AW-1:0] pos;
  logic [AW-1:0] clr;

  logic          accept;
  logic          emit_ok;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [5:0]    mem_wdata;

  hash_req_t     hash_req;
  hash_rsp_t     hash_rsp;
  logic          mod_start;
  logic          mod_done;
  logic [DW-1:0] mod_rem;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign emit_ok  = !out_valid || !out_stall;

  // Clamp the modulus into 1..PHYS_DEPTH
  always_comb begin
    if (phys_count == 13'd0) begin
      used_count = DW'(1);
    end else if (32'(phys_count) > 32'(PHYS_DEPTH)) begin
      used_count = DW'(PHYS_DEPTH);
    end else begin
      used_count = DW'(phys_count);
    end
  end

  always_comb begin
    hash_req.start = (accept && command == CMD_INSERT) || (state == S_HSTART);
    hash_req.key   = (state == S_HSTART) ? src_r : (source ^ destination);
    hash_req.seed  = (state == S_HSTART) ? seed_q : element_seed;
  end

  assign mod_start = (state == S_SHASH) && hash_rsp.done;

  vhll_hash u_hash (
    .clk (clk),
    .rst (rst),
    .req (hash_req),
    .rsp (hash_rsp)
  );

  vhll_mod #(
    .DW (DW)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (hash_rsp.value),
    .divisor   (used_count),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      element_seed <= '0;
      phys_count   <= PHYS_COUNT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ELEMENT_SEED: element_seed <= cfg_data;
        REG_PHYS_COUNT:   phys_count   <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Seed table
  always_ff @(posedge clk) begin
    if (accept && command == CMD_LOAD_SEED) begin
      seeds[VW'(seed_index)] <= seed_value;
    end
    seed_q <= seeds[vidx];
  end

  always_comb begin
    mem_we    = (state == S_CLEAR) || (state == S_USE && is_insert && rank > rank_q);
    mem_waddr = (state == S_CLEAR) ? clr : pos;
    mem_wdata = (state == S_CLEAR) ? 6'd0 : rank;
  end

  // Rank memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ranks[mem_waddr] <= mem_wdata;
    end
    rank_q <= ranks[pos];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (clr == AW'(PHYS_DEPTH - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          case (command)
            CMD_INSERT: state_next = S_EHASH;
            CMD_QUERY:  state_next = S_SEEDRD;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_EHASH:  if (hash_rsp.done) state_next = S_SEEDRD;
      S_SEEDRD: state_next = S_HSTART;
      S_HSTART: state_next = S_SHASH;
      S_SHASH:  if (hash_rsp.done) state_next = S_MOD;
      S_MOD:    if (mod_done) state_next = S_READ;
      S_READ:   state_next = S_USE;
      S_USE:    state_next = is_insert ? S_IDLE : S_EMIT;
      S_EMIT: begin
        if (emit_ok) begin
          state_next = (vidx == VW'(VIRT_COUNT - 1)) ? S_IDLE : S_SEEDRD;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr <= clr + AW'(1);
      if (state == S_EMIT && emit_ok) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_insert <= (command == CMD_INSERT);
      src_r     <= source;
      vidx      <= '0;
    end
    if (state == S_EHASH && hash_rsp.done) begin
      vidx <= hash_rsp.value[VW-1:0];
      rank <= rank_of(hash_rsp.value);
    end
    if (mod_done) pos <= mod_rem[AW-1:0];
    if (state == S_EMIT && emit_ok) begin
      rank_value    <= rank_q;
      virtual_index <= 4'(vidx);
      last          <= (vidx == VW'(VIRT_COUNT - 1));
      vidx          <= vidx + VW'(1);
    end
  end

  a_hash_done_owned: assert property (@(posedge clk) disable iff (rst)
    hash_rsp.done |-> (state == S_EHASH || state == S_SHASH))
    else $error("hash result with no consumer");

  a_mod_done_owned: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> state == S_MOD)
    else $error("remainder result outside position step");

  a_no_beat_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !out_valid)
    else $error("result beat during memory clear");

  a_last_on_final: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> virtual_index == 4'(VIRT_COUNT - 1))
    else $error("last marked on wrong virtual register");

  a_insert_no_beat: assert property (@(posedge clk) disable iff (rst)
    (state == S_USE && is_insert) |=> state == S_IDLE)
    else $error("insert did not return to idle");

endmodule
